>>> design/knnvote_pkg.sv
// ----------------------------------------------------------------------------
// knnvote_pkg
// Shared widths, constants and control structs of the nearest-neighbor vote unit.
// ----------------------------------------------------------------------------
package knnvote_pkg;

  localparam int MAX_NEIGHBORS_DEF = 64;
  localparam int NUM_CLASSES_DEF   = 10;

  localparam int DIST_W  = 15;
  localparam int LABEL_W = 4;
  localparam int CNT_W   = 7;

  localparam logic [CNT_W-1:0] LIST_SIZE_RST = 7'd20;

  // weight = 2^WEIGHT_SHIFT / (distance + DIST_BIAS)
  localparam int WEIGHT_SHIFT = 28;
  localparam int DIST_BIAS    = 16;
  localparam int DIVR_W       = DIST_W + 1;
  localparam int QUO_W        = WEIGHT_SHIFT - $clog2(DIST_BIAS) + 1;
  localparam int SUM_W        = 31;
  localparam int DIV_STEPS    = WEIGHT_SHIFT + 1;
  localparam int STEP_W       = $clog2(DIV_STEPS);

  typedef struct packed {
    logic               ins;
    logic               rot;
    logic [DIST_W-1:0]  cand_dist;
    logic [LABEL_W-1:0] label;
    logic [CNT_W-1:0]   held;
    logic [CNT_W-1:0]   size;
  } cell_ctl_t;

  typedef struct packed {
    logic               clear;
    logic               add;
    logic [LABEL_W-1:0] cls;
    logic [QUO_W-1:0]   weight;
    logic               scan;
  } vote_cmd_t;

endpackage

>>> design/knnvote_cell.sv
// ----------------------------------------------------------------------------
// knnvote_cell
// One slot of the sorted neighbor list: sorted insert and rotate toward head.
// ----------------------------------------------------------------------------
module knnvote_cell
  import knnvote_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [DIST_W-1:0]  prev_dist,
  input  logic [LABEL_W-1:0] prev_label,
  input  logic               prev_ge,
  input  logic [DIST_W-1:0]  next_dist,
  input  logic [LABEL_W-1:0] next_label,
  input  logic [DIST_W-1:0]  head_dist,
  input  logic [LABEL_W-1:0] head_label,
  output logic [DIST_W-1:0]  slot_dist,
  output logic [LABEL_W-1:0] label,
  output logic               ge
);

  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic               occ;
  logic [CNT_W-1:0]   my_idx;

  assign my_idx = CNT_W'(IDX);
  assign occ    = my_idx < ctl.held;
  // held entry that stays ahead of the new item (equal distances stay ahead)
  assign ge     = occ && (dist_r <= ctl.cand_dist);

  always_comb begin
    dist_nxt  = dist_r;
    label_nxt = label_r;
    if (ctl.ins) begin
      if (!ge) begin
        if (prev_ge) begin
          dist_nxt  = ctl.cand_dist;
          label_nxt = ctl.label;
        end else begin
          dist_nxt  = prev_dist;
          label_nxt = prev_label;
        end
      end
    end else if (ctl.rot) begin
      // rotate the first size slots by one, head wraps to the tail
      if (my_idx == ctl.size - CNT_W'(1)) begin
        dist_nxt  = head_dist;
        label_nxt = head_label;
      end else if (my_idx < ctl.size) begin
        dist_nxt  = next_dist;
        label_nxt = next_label;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    label_r <= label_nxt;
  end

  assign slot_dist = dist_r;
  assign label     = label_r;

endmodule

>>> design/knnvote_div.sv
// ----------------------------------------------------------------------------
// knnvote_div
// Restoring divider, one quotient bit per cycle, for 2^28 / divisor.
// ----------------------------------------------------------------------------
module knnvote_div
  import knnvote_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVR_W-1:0] divisor,
  output logic              busy,
  output logic              done,
  output logic [QUO_W-1:0]  quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DIVR_W-1:0] rem_r, rem_nxt;
  logic [DIVR_W-1:0] div_r, div_nxt;
  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic              num_bit;
  logic [DIVR_W:0]   trial;
  logic [DIVR_W:0]   diff;
  logic              fits;

  // the numerator has a single one at bit WEIGHT_SHIFT
  assign num_bit = (step_r == STEP_W'(WEIGHT_SHIFT));
  assign trial   = {rem_r, num_bit};
  assign fits    = trial >= {1'b0, div_r};
  assign diff    = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    quo_nxt  = quo_r;
    if (start && !busy_r) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(WEIGHT_SHIFT);
      rem_nxt  = '0;
      div_nxt  = divisor;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
      quo_nxt  = {quo_r[QUO_W-2:0], fits};
      step_nxt = step_r - STEP_W'(1);
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/knnvote_tally.sv
// ----------------------------------------------------------------------------
// knnvote_tally
// Per-class weight sums and a one-class-per-cycle argmax scan.
// ----------------------------------------------------------------------------
module knnvote_tally
  import knnvote_pkg::*;
#(
  parameter int NUM_CLASSES = NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  vote_cmd_t          cmd,
  output logic               done,
  output logic [LABEL_W-1:0] pred
);

  localparam int CLS_W = $clog2(NUM_CLASSES);

  logic [SUM_W-1:0] sum_r [NUM_CLASSES];
  logic [SUM_W-1:0] best_r, best_nxt;
  logic [CLS_W-1:0] pred_r, pred_nxt;
  logic [CLS_W-1:0] idx_r, idx_nxt;
  logic             scan_r, scan_nxt;
  logic             done_r, done_nxt;
  logic [CLS_W-1:0] add_idx;
  logic [SUM_W-1:0] cur;

  assign add_idx = cmd.cls[CLS_W-1:0];
  assign cur     = sum_r[idx_r];

  always_ff @(posedge clk) begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (cmd.clear) begin
        sum_r[c] <= '0;
      end else if (cmd.add && add_idx == CLS_W'(c)) begin
        sum_r[c] <= sum_r[c] + SUM_W'(cmd.weight);
      end
    end
  end

  always_comb begin
    best_nxt = best_r;
    pred_nxt = pred_r;
    idx_nxt  = idx_r;
    scan_nxt = scan_r;
    done_nxt = 1'b0;
    if (cmd.scan) begin
      scan_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (scan_r) begin
      // strict compare keeps the lower class on ties
      if (idx_r == '0 || cur > best_r) begin
        best_nxt = cur;
        pred_nxt = idx_r;
      end
      if (idx_r == CLS_W'(NUM_CLASSES - 1)) begin
        scan_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + CLS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
      done_r <= done_nxt;
    end
    best_r <= best_nxt;
    pred_r <= pred_nxt;
    idx_r  <= idx_nxt;
  end

  assign done = done_r;
  assign pred = LABEL_W'(pred_r);

endmodule

>>> design/knn_sorted_list_weighted_vote_unit.sv
// ----------------------------------------------------------------------------
// knn_sorted_list_weighted_vote_unit
// Keeps the nearest candidates of a query in a sorted chain of cells and
// gives an inverse-distance weighted class vote for each neighbor count.
// ----------------------------------------------------------------------------
// flow: a candidate is inserted in the cycle it is accepted, one per cycle outside the walk
// a last candidate starts a walk of one result per neighbor count up to the effective list size;
//   each held entry goes through the serial divider and a class scan over all NUM_CLASSES classes,
//   and each entry beyond the held count goes straight to its result; no input during the walk
// throughput: one candidate per cycle outside the walk
// reset: list empty, list_size 20, no result pending; list slots are not cleared
module knn_sorted_list_weighted_vote_unit
  import knnvote_pkg::*;
#(
  parameter int MAX_NEIGHBORS = MAX_NEIGHBORS_DEF,
  parameter int NUM_CLASSES   = NUM_CLASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CNT_W-1:0]   cfg_list_size,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [DIST_W-1:0]  in_distance,
  input  logic [LABEL_W-1:0] in_label,
  input  logic               in_first,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CNT_W-1:0]   out_neighbor_count,
  output logic [LABEL_W-1:0] out_predicted,
  output logic               out_valid_res,
  output logic               out_end_of_run
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEXT = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   list_size_r;
  logic [CNT_W-1:0]   size_eff;
  logic [CNT_W-1:0]   held_r, held_nxt;
  logic [CNT_W-1:0]   held_eff;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic               in_acc;
  logic               label_ok;
  logic               emit;

  logic               out_valid_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [LABEL_W-1:0] out_pred_r;
  logic               out_vres_r;
  logic               out_eor_r;

  cell_ctl_t          ctl;
  vote_cmd_t          vcmd;
  logic               div_start, div_busy, div_done;
  logic [QUO_W-1:0]   div_quo;
  logic [DIVR_W-1:0]  divisor;
  logic               vote_done;
  logic [LABEL_W-1:0] vote_pred;

  logic [DIST_W-1:0]  cell_dist  [MAX_NEIGHBORS];
  logic [LABEL_W-1:0] cell_label [MAX_NEIGHBORS];
  logic               cell_ge    [MAX_NEIGHBORS];

  // effective list size: zero acts as one, clipped to the chain length
  always_comb begin
    if (list_size_r == '0) begin
      size_eff = CNT_W'(1);
    end else if (list_size_r > CNT_W'(MAX_NEIGHBORS)) begin
      size_eff = CNT_W'(MAX_NEIGHBORS);
    end else begin
      size_eff = list_size_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign label_ok = {1'b0, in_label} < (LABEL_W + 1)'(NUM_CLASSES);
  assign emit     = (state_r == ST_EMIT) && (!out_valid_r || out_ready);

  always_comb begin
    if (in_first) begin
      held_eff = '0;
    end else if (held_r > size_eff) begin
      held_eff = size_eff;
    end else begin
      held_eff = held_r;
    end
  end

  always_comb begin
    held_nxt = held_r;
    if (in_acc) begin
      held_nxt = held_eff;
      if (label_ok && held_eff < size_eff) begin
        held_nxt = held_eff + CNT_W'(1);
      end
    end
  end

  assign ctl.ins       = in_acc && label_ok;
  assign ctl.rot       = emit;
  assign ctl.cand_dist = in_distance;
  assign ctl.label     = in_label;
  assign ctl.held      = held_eff;
  assign ctl.size      = size_eff;

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    logic [DIST_W-1:0]  p_dist, n_dist;
    logic [LABEL_W-1:0] p_label, n_label;
    logic               p_ge;
    if (i == 0) begin : g_head
      assign p_dist  = '0;
      assign p_label = '0;
      assign p_ge    = 1'b1;
    end else begin : g_body
      assign p_dist  = cell_dist[i-1];
      assign p_label = cell_label[i-1];
      assign p_ge    = cell_ge[i-1];
    end
    if (i == MAX_NEIGHBORS - 1) begin : g_tail
      assign n_dist  = cell_dist[i];
      assign n_label = cell_label[i];
    end else begin : g_mid
      assign n_dist  = cell_dist[i+1];
      assign n_label = cell_label[i+1];
    end
    knnvote_cell #(
      .IDX(i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_dist (p_dist),
      .prev_label(p_label),
      .prev_ge   (p_ge),
      .next_dist (n_dist),
      .next_label(n_label),
      .head_dist (cell_dist[0]),
      .head_label(cell_label[0]),
      .slot_dist (cell_dist[i]),
      .label     (cell_label[i]),
      .ge        (cell_ge[i])
    );
  end

  assign divisor = {1'b0, cell_dist[0]} + DIVR_W'(DIST_BIAS);

  knnvote_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quo)
  );

  assign vcmd.clear  = in_acc && in_last;
  assign vcmd.add    = (state_r == ST_DIV) && div_done;
  assign vcmd.cls    = cell_label[0];
  assign vcmd.weight = div_quo;
  assign vcmd.scan   = (state_r == ST_DIV) && div_done;

  knnvote_tally #(
    .NUM_CLASSES(NUM_CLASSES)
  ) u_tally (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (vcmd),
    .done (vote_done),
    .pred (vote_pred)
  );

  // walk sequencer: the head cell always holds entry n-1
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    res_valid_nxt = res_valid_r;
    div_start     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_last) begin
          n_nxt     = CNT_W'(1);
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (n_r <= held_r) begin
          div_start     = 1'b1;
          res_valid_nxt = 1'b1;
          state_nxt     = ST_DIV;
        end else begin
          res_valid_nxt = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (vote_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          if (n_r == size_eff) begin
            state_nxt = ST_IDLE;
          end else begin
            n_nxt     = n_r + CNT_W'(1);
            state_nxt = ST_NEXT;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      list_size_r <= LIST_SIZE_RST;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      if (cfg_we) begin
        list_size_r <= cfg_list_size;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    n_r         <= n_nxt;
    res_valid_r <= res_valid_nxt;
    if (emit) begin
      out_count_r <= n_r;
      out_pred_r  <= res_valid_r ? vote_pred : '0;
      out_vres_r  <= res_valid_r;
      out_eor_r   <= (n_r == size_eff);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_neighbor_count = out_count_r;
  assign out_predicted      = out_pred_r;
  assign out_valid_res      = out_vres_r;
  assign out_end_of_run     = out_eor_r;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(MAX_NEIGHBORS))
    else $error("held count beyond chain length");

  a_valid_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    emit && res_valid_r |-> n_r <= held_r)
    else $error("valid vote for an entry that is not held");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    emit && n_r == size_eff |=> state_r == ST_IDLE)
    else $error("walk did not end after the last result");

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_busy)
    else $error("divider busy while accepting candidates");

  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider result outside the divide step");
`endif

endmodule
